FILE: design/fsf_pkg.sv
// shared token class codes and status types for the signature finder
package fsf_pkg;

  localparam int ClassBits = 3;

  typedef enum logic [ClassBits-1:0] {
    CLS_OTHER       = 3'd0,
    CLS_BRACE_OPEN  = 3'd1,
    CLS_BRACE_CLOSE = 3'd2,
    CLS_PAREN_OPEN  = 3'd3,
    CLS_PAREN_CLOSE = 3'd4,
    CLS_SEMICOLON   = 3'd5
  } token_class_t;

  typedef struct packed {
    logic in_signature;
    logic paren_zero;
  } trk_status_t;

  typedef struct packed {
    logic valid;
    logic full;
  } buf_status_t;

endpackage

FILE: design/fsf_tracker.sv
// nesting state and boundary tracking, one token item per step
module fsf_tracker #(
  parameter int INDEX_BITS = 24,
  parameter int POS_BITS   = 32,
  parameter int DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [2:0]            token_class,
  input  logic                  in_preprocessor,
  input  logic [POS_BITS-1:0]   byte_pos,
  input  logic                  first_token,
  output logic                  res_valid,
  output logic [INDEX_BITS-1:0] res_start_index,
  output logic [INDEX_BITS-1:0] res_end_index,
  output logic [POS_BITS-1:0]   res_paren_pos,
  output fsf_pkg::trk_status_t  status
);
  import fsf_pkg::*;

  localparam logic [DEPTH_BITS-1:0] DepthMax = '1;

  logic                  in_signature, in_signature_next;
  logic [DEPTH_BITS-1:0] brace_depth, brace_depth_next;
  logic [DEPTH_BITS-1:0] paren_depth, paren_depth_next;
  logic [INDEX_BITS-1:0] token_count;
  logic                  boundary_seen;
  logic [INDEX_BITS-1:0] last_boundary_index;
  logic [INDEX_BITS-1:0] held_start_index, held_start_index_next;
  logic [POS_BITS-1:0]   held_paren_pos, held_paren_pos_next;

  // state as seen by this item: a new buffer starts from cleared state
  logic                  cur_sig;
  logic [DEPTH_BITS-1:0] cur_brace, cur_paren;
  logic [INDEX_BITS-1:0] idx, cur_last, cur_start;
  logic                  cur_seen;
  logic [POS_BITS-1:0]   cur_ppos;
  logic                  is_boundary;
  token_class_t          cls;

  assign cls       = token_class_t'(token_class);
  assign cur_sig   = first_token ? 1'b0 : in_signature;
  assign cur_brace = first_token ? '0 : brace_depth;
  assign cur_paren = first_token ? '0 : paren_depth;
  assign idx       = first_token ? '0 : token_count;
  assign cur_seen  = first_token ? 1'b0 : boundary_seen;
  assign cur_last  = first_token ? '0 : last_boundary_index;
  assign cur_start = first_token ? '0 : held_start_index;
  assign cur_ppos  = first_token ? '0 : held_paren_pos;

  assign is_boundary = in_preprocessor || cls == CLS_BRACE_CLOSE ||
                       cls == CLS_SEMICOLON || cls == CLS_PAREN_CLOSE;

  always_comb begin
    in_signature_next     = cur_sig;
    brace_depth_next      = cur_brace;
    paren_depth_next      = cur_paren;
    held_start_index_next = cur_start;
    held_paren_pos_next   = cur_ppos;
    res_valid             = 1'b0;
    if (!in_preprocessor) begin
      if (cur_sig) begin
        if (cls == CLS_PAREN_OPEN) begin
          if (cur_paren != DepthMax) paren_depth_next = cur_paren + 1'b1;
        end else if (cls == CLS_PAREN_CLOSE) begin
          if (cur_paren != '0) paren_depth_next = cur_paren - 1'b1;
          // matching close paren ends the signature
          if (cur_paren <= DEPTH_BITS'(1)) begin
            res_valid         = 1'b1;
            in_signature_next = 1'b0;
          end
        end
      end else begin
        case (cls)
          CLS_BRACE_OPEN: begin
            if (cur_brace != DepthMax) brace_depth_next = cur_brace + 1'b1;
          end
          CLS_BRACE_CLOSE: begin
            if (cur_brace != '0) brace_depth_next = cur_brace - 1'b1;
          end
          CLS_PAREN_OPEN: begin
            if (cur_brace == '0) begin
              in_signature_next     = 1'b1;
              paren_depth_next      = DEPTH_BITS'(1);
              held_paren_pos_next   = byte_pos;
              held_start_index_next = cur_seen ? cur_last + 1'b1 : '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign res_start_index = cur_start;
  assign res_end_index   = idx;
  assign res_paren_pos   = cur_ppos;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_signature        <= 1'b0;
      brace_depth         <= '0;
      paren_depth         <= '0;
      token_count         <= '0;
      boundary_seen       <= 1'b0;
      last_boundary_index <= '0;
      held_start_index    <= '0;
      held_paren_pos      <= '0;
    end else if (step) begin
      in_signature     <= in_signature_next;
      brace_depth      <= brace_depth_next;
      paren_depth      <= paren_depth_next;
      token_count      <= idx + 1'b1;
      held_start_index <= held_start_index_next;
      held_paren_pos   <= held_paren_pos_next;
      boundary_seen    <= cur_seen | is_boundary;
      last_boundary_index <= is_boundary ? idx : cur_last;
    end
  end

  assign status.in_signature = in_signature;
  assign status.paren_zero   = (paren_depth == '0);

endmodule

FILE: design/fsf_out_buf.sv
// two-entry result buffer that absorbs results while the receiver's ready is low
module fsf_out_buf #(
  parameter int WIDTH = 80
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [WIDTH-1:0]     out_data,
  output fsf_pkg::buf_status_t status
);
  import fsf_pkg::*;

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign status.valid = out_valid;
  assign status.full  = (count == 2'd2);

endmodule

FILE: design/function_signature_finder.sv
// top level of the function signature finder
//
// Input channel (tok_valid/tok_ready) carries one classified C/C++ token per
// item: token_class, in_preprocessor, byte_pos and first_token. The output
// channel (sig_valid/sig_ready) carries one item per completed signature:
// start token index, end token index (the matching close paren) and the
// byte offset of the opening paren. Tokens that close no signature give
// no output item.
// An accepted token sits in an input register, is folded into the nesting
// state by the tracker and, if it closes a signature, lands in a two-entry
// output buffer that drives sig_valid. Throughput is one token per cycle
// while no result is blocked by a full buffer; the tracker makes a single
// state update per token.
// When the receiver stalls, the buffer absorbs up to two results; after that
// a token that would produce a result waits in the input register and
// tok_ready drops. Tokens producing no result keep flowing meanwhile.
// Reset clears all nesting state, token counters and valid flags; an item
// with first_token set clears the tracker's nesting state and counters only.
module function_signature_finder #(
  parameter int INDEX_BITS = 24,
  parameter int POS_BITS   = 32,
  parameter int DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tok_valid,
  output logic                  tok_ready,
  input  logic [2:0]            token_class,
  input  logic                  in_preprocessor,
  input  logic [POS_BITS-1:0]   byte_pos,
  input  logic                  first_token,
  output logic                  sig_valid,
  input  logic                  sig_ready,
  output logic [INDEX_BITS-1:0] start_index,
  output logic [INDEX_BITS-1:0] end_index,
  output logic [POS_BITS-1:0]   paren_pos
);
  import fsf_pkg::*;

  localparam int ResWidth = 2 * INDEX_BITS + POS_BITS;

  logic                  hold_valid;
  logic [2:0]            hold_class;
  logic                  hold_pre;
  logic [POS_BITS-1:0]   hold_pos;
  logic                  hold_first;
  logic                  advance;
  logic                  res_valid;
  logic [INDEX_BITS-1:0] res_start, res_end;
  logic [POS_BITS-1:0]   res_ppos;
  logic [ResWidth-1:0]   buf_data;
  trk_status_t           trk_status;
  buf_status_t           buf_status;

  // a token moves on unless its result has nowhere to go
  assign advance   = hold_valid && (!res_valid || !buf_status.full);
  assign tok_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (tok_ready) begin
      hold_valid <= tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid && tok_ready) begin
      hold_class <= token_class;
      hold_pre   <= in_preprocessor;
      hold_pos   <= byte_pos;
      hold_first <= first_token;
    end
  end

  fsf_tracker #(
    .INDEX_BITS(INDEX_BITS),
    .POS_BITS  (POS_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_tracker (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .token_class    (hold_class),
    .in_preprocessor(hold_pre),
    .byte_pos       (hold_pos),
    .first_token    (hold_first),
    .res_valid      (res_valid),
    .res_start_index(res_start),
    .res_end_index  (res_end),
    .res_paren_pos  (res_ppos),
    .status         (trk_status)
  );

  fsf_out_buf #(
    .WIDTH(ResWidth)
  ) u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (advance && res_valid),
    .push_data({res_start, res_end, res_ppos}),
    .out_valid(sig_valid),
    .out_ready(sig_ready),
    .out_data (buf_data),
    .status   (buf_status)
  );

  assign start_index = buf_data[ResWidth-1 -: INDEX_BITS];
  assign end_index   = buf_data[POS_BITS +: INDEX_BITS];
  assign paren_pos   = buf_data[POS_BITS-1:0];

  // an open signature always has at least one paren open
  a_sig_depth: assert property (@(posedge clk) disable iff (rst)
    trk_status.in_signature |-> !trk_status.paren_zero)
    else $error("signature open with zero paren depth");

  // a pushed result shows up on the output next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (advance && res_valid) |=> sig_valid)
    else $error("pushed result not visible");

  // ready only drops while a token is held and its result is blocked
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !tok_ready |-> (hold_valid && res_valid && buf_status.full))
    else $error("input stalled without cause");

endmodule
